// File: rtl/gtr_pkg.sv
// Shared types, constants and the 5x7 font table of the glyph text rasterizer.
// No dependencies; the top level, font ROM, pixel walker and bench import this package.
`timescale 1ns / 1ps
`default_nettype none

package gtr_pkg;

   typedef enum logic {
      KIND_DRAW   = 1'b0,
      KIND_CURSOR = 1'b1
   } kind_type;

   typedef enum logic {
      CSR_FG_COLOR = 1'b0,
      CSR_BG_COLOR = 1'b1
   } csr_index_type;

   localparam int unsigned GLYPH_COUNT = 95;

   localparam logic [7:0] GLYPH_FIRST    = 8'd32;
   localparam logic [7:0] GLYPH_LAST     = 8'd126;
   localparam logic [7:0] ADVANCE_X      = 8'd6;
   localparam logic [7:0] WRAP_LIMIT     = 8'd127;
   localparam logic [7:0] WRAP_COL       = 8'd4;
   localparam logic [7:0] WRAP_ADVANCE_Y = 8'd15;
   localparam logic [2:0] LAST_ROW       = 3'd6;
   localparam logic [2:0] LAST_COL       = 3'd4;
   localparam logic [15:0] FG_RESET      = 16'hFFFF;
   localparam logic [15:0] BG_RESET      = 16'h0000;

   // One glyph is five column bytes, column 0 in the top byte. Bit r of a
   // column byte is row r of that column.
   typedef logic [39:0] glyph_type;

   localparam glyph_type GLYPH_TABLE [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00004f0000, 40'h0007000700,
      40'h147f147f14, 40'h242a7f2a12, 40'h2313086462,
      40'h3649552250, 40'h0005030000, 40'h001c224100,
      40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3e5149453e, 40'h00427f4000,
      40'h4261514946, 40'h2141454b31, 40'h1814127f10,
      40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000,
      40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h324979413e,
      40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901,
      40'h3e4149497a, 40'h7f0808087f, 40'h00417f4100,
      40'h2040413f01, 40'h7f08142241, 40'h7f40404040,
      40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946,
      40'h4649494931, 40'h01017f0101, 40'h3f4040403f,
      40'h1f2040201f, 40'h3f4038403f, 40'h6314081463,
      40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204,
      40'h4040404040, 40'h0001020400, 40'h2054545478,
      40'h7f48444438, 40'h3844444420, 40'h384444487f,
      40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00,
      40'h7f10284400, 40'h00417f4000, 40'h7c04180478,
      40'h7c08040478, 40'h3844444438, 40'h7c14141408,
      40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c,
      40'h3c4030403c, 40'h4428102844, 40'h0c5050503c,
      40'h4464544c44, 40'h0008364100, 40'h00007f0000,
      40'h0041360800, 40'h0201020402
   };

   // Start of one character's pixel walk.
   typedef struct packed {
      logic       start;
      logic [7:0] base_x;
      logic [7:0] base_y;
   } raster_cmd_type;

   typedef struct packed {
      logic take_next;
   } raster_status_type;

endpackage : gtr_pkg

`default_nettype wire

// File: rtl/gtr_ifs.sv
// Valid/ready channel interfaces for the request and pixel streams.
// Depends on nothing but the field widths of the block.
`timescale 1ns / 1ps
`default_nettype none

interface gtr_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] char_code;
   logic [7:0] set_x;
   logic [7:0] set_y;

   modport source (output valid, kind, char_code, set_x, set_y, input ready);
   modport sink (input valid, kind, char_code, set_x, set_y, output ready);
endinterface : gtr_req_if

interface gtr_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  pixel_x;
   logic [7:0]  pixel_y;
   logic [15:0] pixel_color;
   logic        last_pixel;

   modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
   modport sink (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface : gtr_rsp_if

`default_nettype wire

// File: rtl/glyph_text_rasterizer_top.sv
// Top level of the glyph text rasterizer: cursor, color registers, font ROM and pixel walker.
// Depends on gtr_pkg, gtr_ifs, gtr_glyph_rom and gtr_raster.
`timescale 1ns / 1ps
`default_nettype none

// A draw item produces 35 pixels, one per clock while the result side takes
// them. The glyph is read from the font ROM at the edge that accepts the item
// and is ready for the first pixel on the next cycle, and the next item is
// taken in the cycle the 35th pixel enters the output register, so characters
// stream without gaps. A cursor-set item produces no pixel; it is taken only
// when a draw item could be, so it waits while a character is being walked
// until the last pixel enters the output register. Color registers should be
// written only while no character is in flight.
module glyph_text_rasterizer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   gtr_req_if.sink          req_ch,
   gtr_rsp_if.source        rsp_ch,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import gtr_pkg::*;

   logic [7:0]  cursor_x_ff, cursor_x_in;
   logic [7:0]  cursor_y_ff, cursor_y_in;
   logic [15:0] fg_color_ff, bg_color_ff;

   logic              req_fire;
   logic              draw_fire;
   logic [7:0]        adv_x;
   raster_cmd_type    cmd;
   raster_status_type status;
   glyph_type         glyph;

   assign req_ch.ready = status.take_next;
   assign req_fire     = req_ch.valid && status.take_next;
   assign draw_fire    = req_fire && (kind_type'(req_ch.kind) == KIND_DRAW);

   assign adv_x = cursor_x_ff + ADVANCE_X;

   always_comb begin
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      if (req_fire) begin
         if (kind_type'(req_ch.kind) == KIND_CURSOR) begin
            cursor_x_in = req_ch.set_x;
            cursor_y_in = req_ch.set_y;
         end else if (adv_x > WRAP_LIMIT) begin
            // The 8-bit advance wraps before the line-wrap test.
            cursor_x_in = WRAP_COL;
            cursor_y_in = cursor_y_ff + WRAP_ADVANCE_Y;
         end else begin
            cursor_x_in = adv_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         fg_color_ff <= FG_RESET;
         bg_color_ff <= BG_RESET;
      end else begin
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_FG_COLOR: fg_color_ff <= csr_wdata;
               CSR_BG_COLOR: bg_color_ff <= csr_wdata;
               default:      fg_color_ff <= fg_color_ff;
            endcase
         end
      end
   end

   assign cmd.start  = draw_fire;
   assign cmd.base_x = cursor_x_ff;
   assign cmd.base_y = cursor_y_ff;

   gtr_glyph_rom u_rom (
      .clock     (clock),
      .rd_en     (draw_fire),
      .char_code (req_ch.char_code),
      .glyph     (glyph)
   );

   gtr_raster u_raster (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .glyph    (glyph),
      .fg_color (fg_color_ff),
      .bg_color (bg_color_ff),
      .status   (status),
      .rsp      (rsp_ch)
   );

endmodule : glyph_text_rasterizer_top

`default_nettype wire

// File: rtl/gtr_glyph_rom.sv
// Font ROM with a registered read port: one glyph (five column bytes) per read.
// Depends on gtr_pkg for the font table and range constants.
`timescale 1ns / 1ps
`default_nettype none

module gtr_glyph_rom (
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [7:0]        char_code,
   output gtr_pkg::glyph_type     glyph
);
   import gtr_pkg::*;

   logic       in_range;
   logic [6:0] rom_addr;
   glyph_type  glyph_ff;

   assign in_range = (char_code >= GLYPH_FIRST) && (char_code <= GLYPH_LAST);
   assign rom_addr = 7'(char_code - GLYPH_FIRST);

   // Codes outside the printable range read as a blank glyph.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         glyph_ff <= in_range ? GLYPH_TABLE[rom_addr] : '0;
      end
   end

   assign glyph = glyph_ff;

endmodule : gtr_glyph_rom

`default_nettype wire

// File: rtl/gtr_raster.sv
// Pixel walker: steps rows 0..6 and columns 0..4 of one glyph into an output register.
// Depends on gtr_pkg and the gtr_rsp_if interface; glyph data comes from gtr_glyph_rom.
`timescale 1ns / 1ps
`default_nettype none

module gtr_raster (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire gtr_pkg::raster_cmd_type    cmd,
   input  wire gtr_pkg::glyph_type         glyph,
   input  wire logic [15:0]                fg_color,
   input  wire logic [15:0]                bg_color,
   output gtr_pkg::raster_status_type      status,
   gtr_rsp_if.source                       rsp
);
   import gtr_pkg::*;

   logic        busy_ff, busy_in;
   logic [2:0]  row_ff, row_in;
   logic [2:0]  col_ff, col_in;
   logic [7:0]  base_x_ff, base_y_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  pixel_x_ff, pixel_y_ff;
   logic [15:0] pixel_color_ff;
   logic        last_pixel_ff;

   logic        fire;
   logic        last_pos;
   logic [7:0]  col_byte;
   logic        pixel_on;

   assign last_pos = (row_ff == LAST_ROW) && (col_ff == LAST_COL);
   // A pixel moves into the output register when it is empty or being drained.
   assign fire     = busy_ff && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      case (col_ff)
         3'd0:    col_byte = glyph[39:32];
         3'd1:    col_byte = glyph[31:24];
         3'd2:    col_byte = glyph[23:16];
         3'd3:    col_byte = glyph[15:8];
         3'd4:    col_byte = glyph[7:0];
         default: col_byte = 8'h00;
      endcase
   end

   assign pixel_on = col_byte[row_ff];

   always_comb begin
      busy_in = busy_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         row_in  = '0;
         col_in  = '0;
      end else if (fire) begin
         if (last_pos) begin
            busy_in = 1'b0;
         end else if (col_ff == LAST_COL) begin
            col_in = '0;
            row_in = row_ff + 3'd1;
         end else begin
            col_in = col_ff + 3'd1;
         end
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         base_x_ff <= cmd.base_x;
         base_y_ff <= cmd.base_y;
      end
      if (fire) begin
         pixel_x_ff     <= base_x_ff + {5'd0, col_ff};
         pixel_y_ff     <= base_y_ff + {5'd0, row_ff};
         pixel_color_ff <= pixel_on ? fg_color : bg_color;
         last_pixel_ff  <= last_pos;
      end
   end

   assign status.take_next = !busy_ff || (fire && last_pos);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.pixel_x     = pixel_x_ff;
   assign rsp.pixel_y     = pixel_y_ff;
   assign rsp.pixel_color = pixel_color_ff;
   assign rsp.last_pixel  = last_pixel_ff;

endmodule : gtr_raster

`default_nettype wire

// File: rtl/gtr_checker.sv
// Port-level checks on the glyph text rasterizer and the bind that attaches them.
// Depends on glyph_text_rasterizer_top and its channel interfaces.
`timescale 1ns / 1ps
`default_nettype none

module gtr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_pixel_x,
   input wire logic [7:0]  rsp_pixel_y,
   input wire logic        rsp_last_pixel
);
   logic       rsp_fire;
   logic [5:0] count_ff, count_in;
   logic [2:0] col_ff, col_in;
   logic [7:0] prev_x_ff;
   logic [7:0] prev_y_ff;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      count_in = count_ff;
      col_in   = col_ff;
      if (rsp_fire) begin
         count_in = (count_ff == 6'd34) ? 6'd0 : count_ff + 6'd1;
         col_in   = (col_ff == 3'd4) ? 3'd0 : col_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         col_ff   <= '0;
      end else begin
         count_ff <= count_in;
         col_ff   <= col_in;
      end
      if (rsp_fire) begin
         prev_x_ff <= rsp_pixel_x;
         prev_y_ff <= rsp_pixel_y;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel output valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("pixel dropped while stalled");

   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_last_pixel == (count_ff == 6'd34)))
      else $error("last_pixel not on the 35th pixel of a character");

   a_row_walk: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && (col_ff != 3'd0) |->
         (rsp_pixel_y == prev_y_ff) && (rsp_pixel_x == prev_x_ff + 8'd1))
      else $error("pixel within a glyph row out of sequence");

endmodule : gtr_checker

bind glyph_text_rasterizer_top gtr_checker u_gtr_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pixel_x    (rsp_ch.pixel_x),
   .rsp_pixel_y    (rsp_ch.pixel_y),
   .rsp_last_pixel (rsp_ch.last_pixel)
);

`default_nettype wire

// File: test/tb_glyph_text_rasterizer_top.sv
// Self-checking bench for glyph_text_rasterizer_top: draw and cursor items against a 5x7 font
// walk. Depends on gtr_pkg, the gtr_req_if/gtr_rsp_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_glyph_text_rasterizer_top;
   import gtr_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam int PHASE_ITEMS   = 70;

   localparam logic [7:0] FIRST_CODE = 8'd32;
   localparam logic [7:0] LAST_CODE  = 8'd126;
   localparam logic [7:0] STEP_X     = 8'd6;
   localparam logic [7:0] WRAP_AT    = 8'd127;
   localparam logic [7:0] WRAP_X     = 8'd4;
   localparam logic [7:0] LINE_STEP  = 8'd15;

   // Five column bytes per printable character; bit r of a byte is row r.
   localparam logic [7:0] FONT_COLS [95][5] = '{
      '{'h00,'h00,'h00,'h00,'h00}, '{'h00,'h00,'h4f,'h00,'h00}, '{'h00,'h07,'h00,'h07,'h00},
      '{'h14,'h7f,'h14,'h7f,'h14}, '{'h24,'h2a,'h7f,'h2a,'h12}, '{'h23,'h13,'h08,'h64,'h62},
      '{'h36,'h49,'h55,'h22,'h50}, '{'h00,'h05,'h03,'h00,'h00}, '{'h00,'h1c,'h22,'h41,'h00},
      '{'h00,'h41,'h22,'h1c,'h00}, '{'h14,'h08,'h3e,'h08,'h14}, '{'h08,'h08,'h3e,'h08,'h08},
      '{'h00,'h50,'h30,'h00,'h00}, '{'h08,'h08,'h08,'h08,'h08}, '{'h00,'h60,'h60,'h00,'h00},
      '{'h20,'h10,'h08,'h04,'h02}, '{'h3e,'h51,'h49,'h45,'h3e}, '{'h00,'h42,'h7f,'h40,'h00},
      '{'h42,'h61,'h51,'h49,'h46}, '{'h21,'h41,'h45,'h4b,'h31}, '{'h18,'h14,'h12,'h7f,'h10},
      '{'h27,'h45,'h45,'h45,'h39}, '{'h3c,'h4a,'h49,'h49,'h30}, '{'h01,'h71,'h09,'h05,'h03},
      '{'h36,'h49,'h49,'h49,'h36}, '{'h06,'h49,'h49,'h29,'h1e}, '{'h00,'h36,'h36,'h00,'h00},
      '{'h00,'h56,'h36,'h00,'h00}, '{'h08,'h14,'h22,'h41,'h00}, '{'h14,'h14,'h14,'h14,'h14},
      '{'h00,'h41,'h22,'h14,'h08}, '{'h02,'h01,'h51,'h09,'h06}, '{'h32,'h49,'h79,'h41,'h3e},
      '{'h7e,'h11,'h11,'h11,'h7e}, '{'h7f,'h49,'h49,'h49,'h36}, '{'h3e,'h41,'h41,'h41,'h22},
      '{'h7f,'h41,'h41,'h22,'h1c}, '{'h7f,'h49,'h49,'h49,'h41}, '{'h7f,'h09,'h09,'h09,'h01},
      '{'h3e,'h41,'h49,'h49,'h7a}, '{'h7f,'h08,'h08,'h08,'h7f}, '{'h00,'h41,'h7f,'h41,'h00},
      '{'h20,'h40,'h41,'h3f,'h01}, '{'h7f,'h08,'h14,'h22,'h41}, '{'h7f,'h40,'h40,'h40,'h40},
      '{'h7f,'h02,'h0c,'h02,'h7f}, '{'h7f,'h04,'h08,'h10,'h7f}, '{'h3e,'h41,'h41,'h41,'h3e},
      '{'h7f,'h09,'h09,'h09,'h06}, '{'h3e,'h41,'h51,'h21,'h5e}, '{'h7f,'h09,'h19,'h29,'h46},
      '{'h46,'h49,'h49,'h49,'h31}, '{'h01,'h01,'h7f,'h01,'h01}, '{'h3f,'h40,'h40,'h40,'h3f},
      '{'h1f,'h20,'h40,'h20,'h1f}, '{'h3f,'h40,'h38,'h40,'h3f}, '{'h63,'h14,'h08,'h14,'h63},
      '{'h07,'h08,'h70,'h08,'h07}, '{'h61,'h51,'h49,'h45,'h43}, '{'h00,'h7f,'h41,'h41,'h00},
      '{'h02,'h04,'h08,'h10,'h20}, '{'h00,'h41,'h41,'h7f,'h00}, '{'h04,'h02,'h01,'h02,'h04},
      '{'h40,'h40,'h40,'h40,'h40}, '{'h00,'h01,'h02,'h04,'h00}, '{'h20,'h54,'h54,'h54,'h78},
      '{'h7f,'h48,'h44,'h44,'h38}, '{'h38,'h44,'h44,'h44,'h20}, '{'h38,'h44,'h44,'h48,'h7f},
      '{'h38,'h54,'h54,'h54,'h18}, '{'h08,'h7e,'h09,'h01,'h02}, '{'h0c,'h52,'h52,'h52,'h3e},
      '{'h7f,'h08,'h04,'h04,'h78}, '{'h00,'h44,'h7d,'h40,'h00}, '{'h20,'h40,'h44,'h3d,'h00},
      '{'h7f,'h10,'h28,'h44,'h00}, '{'h00,'h41,'h7f,'h40,'h00}, '{'h7c,'h04,'h18,'h04,'h78},
      '{'h7c,'h08,'h04,'h04,'h78}, '{'h38,'h44,'h44,'h44,'h38}, '{'h7c,'h14,'h14,'h14,'h08},
      '{'h08,'h14,'h14,'h18,'h7c}, '{'h7c,'h08,'h04,'h04,'h08}, '{'h48,'h54,'h54,'h54,'h20},
      '{'h04,'h3f,'h44,'h40,'h20}, '{'h3c,'h40,'h40,'h20,'h7c}, '{'h1c,'h20,'h40,'h20,'h1c},
      '{'h3c,'h40,'h30,'h40,'h3c}, '{'h44,'h28,'h10,'h28,'h44}, '{'h0c,'h50,'h50,'h50,'h3c},
      '{'h44,'h64,'h54,'h4c,'h44}, '{'h00,'h08,'h36,'h41,'h00}, '{'h00,'h00,'h7f,'h00,'h00},
      '{'h00,'h41,'h36,'h08,'h00}, '{'h02,'h01,'h02,'h04,'h02}
   };

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  code;
      logic [7:0]  x;
      logic [7:0]  y;
      logic        typed;
      logic [7:0]  tx;
      logic [7:0]  ty;
      logic [15:0] tcolor;
   } stim_row_type;

   typedef struct packed {
      logic [7:0]  x;
      logic [7:0]  y;
      logic [15:0] color;
      logic        last;
   } pixel_type;

   // Rows with typed set are blank glyphs whose base and color follow directly
   // from the reset state and the cursor walk; the rest go through the predictor.
   localparam int N_DIRECTED = 22;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      '{KIND_DRAW,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd255, 8'd0,   8'd0,   1'b1, 8'd6,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd32,  8'd0,   8'd0,   1'b1, 8'd12, 8'd0, 16'h0000},
      '{KIND_DRAW,   8'd31,  8'd0,   8'd0,   1'b1, 8'd18, 8'd0, 16'h0000},
      '{KIND_DRAW,   8'd127, 8'd0,   8'd0,   1'b1, 8'd24, 8'd0, 16'h0000},
      '{KIND_DRAW,   8'd126, 8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd33,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd65,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_CURSOR, 8'hFF,  8'd122, 8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd87,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd35,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_CURSOR, 8'h41,  8'd255, 8'd255, 1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd56,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd64,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_CURSOR, 8'd0,   8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd127, 8'hFF,  8'hFF,  1'b1, 8'd0,  8'd0, 16'h0000},
      '{KIND_CURSOR, 8'd0,   8'd121, 8'd241, 1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd122, 8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd103, 8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd0,   8'd0,   8'd0,   1'b1, 8'd4,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd77,  8'd0,   8'd0,   1'b0, 8'd0,  8'd0, 16'h0000},
      '{KIND_DRAW,   8'd128, 8'd0,   8'd0,   1'b1, 8'd16, 8'd0, 16'h0000}
   };

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic        csr_index;
   logic [15:0] csr_wdata;

   gtr_req_if req_ch ();
   gtr_rsp_if rsp_ch ();

   glyph_text_rasterizer_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   pixel_type   pixel_queue [$];
   logic [7:0]  cur_col;
   logic [7:0]  cur_row;
   logic [15:0] fg_shadow;
   logic [15:0] bg_shadow;

   int error_count    = 0;
   int pixels_checked = 0;
   int chars_sent     = 0;
   int blank_chars    = 0;
   int cursor_loads   = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   bit sender_steady  = 1'b0;
   bit hold_request   = 1'b0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Queues the 35 pixels of one glyph placed at (bx, by).
   task automatic queue_walk(input logic [7:0] bx, input logic [7:0] by,
                             input logic [4:0][7:0] glyph,
                             input logic [15:0] on_color, input logic [15:0] off_color);
      pixel_type px;
      for (int r = 0; r < 7; r++) begin
         for (int c = 0; c < 5; c++) begin
            px.x     = bx + 8'(c);
            px.y     = by + 8'(r);
            px.color = glyph[c][r] ? on_color : off_color;
            px.last  = (r == 6 && c == 4);
            pixel_queue.push_back(px);
         end
      end
   endtask

   task automatic put_req(input stim_row_type item);
      logic [4:0][7:0] glyph;
      int gap;
      @(negedge clock);
      if (!sender_steady && burst_left == 0) begin
         req_ch.valid = 1'b0;
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 7);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_ch.kind      = item.kind;
      req_ch.char_code = item.code;
      req_ch.set_x     = item.x;
      req_ch.set_y     = item.y;
      req_ch.valid     = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (burst_left > 0) burst_left--;

      if (item.kind == KIND_CURSOR) begin
         cur_col = item.x;
         cur_row = item.y;
         cursor_loads++;
      end else begin
         chars_sent++;
         for (int c = 0; c < 5; c++)
            glyph[c] = (item.code >= FIRST_CODE && item.code <= LAST_CODE) ?
                       FONT_COLS[item.code - FIRST_CODE][c] : 8'h00;
         if (glyph == '0) blank_chars++;
         if (item.typed)
            queue_walk(item.tx, item.ty, '0, fg_shadow, item.tcolor);
         else
            queue_walk(cur_col, cur_row, glyph, fg_shadow, bg_shadow);
         // The column advance wraps at 8 bits before the line-wrap test.
         cur_col = cur_col + STEP_X;
         if (cur_col > WRAP_AT) begin
            cur_col = WRAP_X;
            cur_row = cur_row + LINE_STEP;
         end
      end
   endtask

   function automatic stim_row_type random_item();
      stim_row_type item;
      item      = '0;
      item.code = 8'($urandom_range(0, 255));
      item.x    = 8'($urandom_range(0, 255));
      item.y    = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 99) < 12) begin
         item.kind = KIND_CURSOR;
         // Bias some loads toward the line wrap and the 8-bit column wrap.
         case ($urandom_range(0, 2))
            0: item.x = 8'($urandom_range(100, 127));
            1: item.x = 8'($urandom_range(240, 255));
            default: ;
         endcase
      end else begin
         item.kind = KIND_DRAW;
         if ($urandom_range(0, 4) != 0)
            item.code = 8'($urandom_range(FIRST_CODE, LAST_CODE));
      end
      return item;
   endfunction

   task automatic drain_pixels();
      @(negedge clock);
      req_ch.valid = 1'b0;
      burst_left   = 0;
      while (pixel_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_colors(input logic [15:0] fg, input logic [15:0] bg);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = CSR_FG_COLOR;
      csr_wdata = fg;
      @(negedge clock);
      csr_index = CSR_BG_COLOR;
      csr_wdata = bg;
      @(negedge clock);
      csr_we    = 1'b0;
      fg_shadow = fg;
      bg_shadow = bg;
   endtask

   initial begin : stimulus
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = CSR_FG_COLOR;
      csr_wdata        = '0;
      req_ch.valid     = 1'b0;
      req_ch.kind      = KIND_DRAW;
      req_ch.char_code = '0;
      req_ch.set_x     = '0;
      req_ch.set_y     = '0;
      cur_col          = '0;
      cur_row          = '0;
      fg_shadow        = 16'hFFFF;
      bg_shadow        = 16'h0000;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int n = 0; n < N_DIRECTED; n++) put_req(DIRECTED[n]);

      for (int ph = 0; ph < 5; ph++) begin
         drain_pixels();
         case (ph)
            0: write_colors(16'h0000, 16'hFFFF);
            1: write_colors(16'hF800, 16'h07E0);
            2, 3: write_colors(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            default: write_colors(16'hFFFF, 16'h0000);
         endcase
         sender_steady = (ph == 1);
         if (ph == 2) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) put_req(random_item());
      end
      drain_pixels();

      $display("Sent %0d characters (%0d blank) and %0d cursor loads under six color settings;",
               chars_sent, blank_chars, cursor_loads);
      $display("compared %0d pixels, with line and column wraparound and a long output stall.",
               pixels_checked);
      if (error_count == 0)
         $display("tb_glyph_text_rasterizer_top: clean");
      else
         $display("tb_glyph_text_rasterizer_top: errors");
      $finish;
   end

   // The pixel side cycles through stall patterns and takes one long hold-off on request.
   initial begin : pixel_sink
      int rx_cycle;
      int hold_left;
      rx_cycle     = 0;
      hold_left    = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_ch.ready = 1'b0;
            hold_left--;
         end else begin
            case ((rx_cycle / 97) % 4)
               0: rsp_ch.ready = 1'b1;
               1: rsp_ch.ready = ($urandom_range(0, 3) != 0);
               2: rsp_ch.ready = ((rx_cycle % 5) < 3);
               default: rsp_ch.ready = 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   always @(posedge clock) begin : pixel_check
      pixel_type got;
      pixel_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got = {rsp_ch.pixel_x, rsp_ch.pixel_y, rsp_ch.pixel_color, rsp_ch.last_pixel};
         if (pixel_queue.size() == 0) begin
            error_count++;
            $display("%0t: unexpected pixel x=%0d y=%0d color=%h last=%b", $time,
                     got.x, got.y, got.color, got.last);
         end else begin
            want = pixel_queue.pop_front();
            pixels_checked++;
            if (got !== want) begin
               error_count++;
               $display("%0t: expected x=%0d y=%0d color=%h last=%b, got x=%0d y=%0d color=%h last=%b",
                        $time, want.x, want.y, want.color, want.last,
                        got.x, got.y, got.color, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out at cycle %0d with %0d pixels outstanding.", cycle_count,
                  pixel_queue.size());
         $display("tb_glyph_text_rasterizer_top: errors");
         $finish;
      end
   end

endmodule
